@@ design/arc_pkg.sv @@
package arc_pkg;

  localparam int CHAR_W      = 8;
  localparam int BASE_W      = 6;
  localparam int BASE_MIN    = 2;
  localparam int BASE_MAX    = 36;
  localparam int DEC_DIGITS  = 10;
  localparam int BUF_DEPTH   = 64;
  localparam int BUF_AW      = 6;
  localparam int CNT_W       = 7;
  localparam int MAX_DIGITS  = BUF_DEPTH - 1;
  localparam int CMDQ_DEPTH  = 2;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;
  localparam int CFG_IDX_BIT = 2;

  localparam logic REG_SRC_BASE = 1'b0;
  localparam logic REG_TGT_BASE = 1'b1;

  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_RANGE    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_ECHO  = 2'd0,
    CMD_SIGN  = 2'd1,
    CMD_DIGIT = 2'd2
  } cmd_kind_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_EXEC,
    BK_ACC,
    BK_END,
    BK_DIV,
    BK_NEXT,
    BK_SIGN,
    BK_RD,
    BK_EMIT
  } back_state_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_in;
    logic              last_in;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    status_t           status;
    logic              last_out;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [CHAR_W-1:0] chr;
    logic [BASE_W-1:0] digit;
    status_t           code;
    logic              last;
  } cmd_t;

  function automatic logic [BASE_W-1:0] eff_base(input logic [BASE_W-1:0] v);
    if (v < BASE_W'(BASE_MIN)) return BASE_W'(BASE_MIN);
    if (v > BASE_W'(BASE_MAX)) return BASE_W'(BASE_MAX);
    return v;
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UZ) ||
           (c >= CH_LA && c <= CH_LZ);
  endfunction

  function automatic logic [BASE_W-1:0] char_value(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] v;
    if (c >= CH_0 && c <= CH_9) begin
      v = c - CH_0;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      v = c - CH_UA + CHAR_W'(DEC_DIGITS);
    end else begin
      v = c - CH_LA + CHAR_W'(DEC_DIGITS);
    end
    return v[BASE_W-1:0];
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {{(CHAR_W-BASE_W){1'b0}}, d};
    if (d < BASE_W'(DEC_DIGITS)) return CH_0 + dx;
    return CH_UA + dx - CHAR_W'(DEC_DIGITS);
  endfunction

endpackage

@@ design/ascii_radix_converter.sv @@
// Streaming radix converter: feed a signed ASCII numeral one character per
// request (optional leading '+' or '-', digits 0-9/A-Z/a-z), mark the final
// character with last_in, and the block returns the value in the target base
// with uppercase digits, most significant first, or a single error result
// (invalid character, digit beyond the base, overflow) with char_out zero.
// When the two bases are equal (out-of-range bases clamp to 2..36) every
// character comes straight back. A two-entry command queue separates the
// classifier from the execution engine, so the input keeps taking characters
// while results are still waiting. Timing: in the engine an echoed
// character passes through EXEC, a digit also through ACC for the registered
// multiply-add of the accumulator; on the final character each output digit
// is produced by the divider, which retires eight quotient bits per cycle,
// then read back from the digit buffer and presented. The digit buffer needs
// no clearing after reset.
module ascii_radix_converter #(
  parameter int VALUE_BITS = 63
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  arc_pkg::in_item_t           in_data,
  output logic                        out_empty,
  input  logic                        out_pop,
  output arc_pkg::out_item_t          out_data,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [arc_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [arc_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [arc_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  logic [arc_pkg::BASE_W-1:0] src_base_r;
  logic [arc_pkg::BASE_W-1:0] tgt_base_r;
  logic [arc_pkg::BASE_W-1:0] src_eff;
  logic [arc_pkg::BASE_W-1:0] tgt_eff;
  logic                       cfg_wr;
  logic                       reg_idx;
  logic                       accept;
  arc_pkg::cmd_t              front_cmd;
  arc_pkg::cmd_t              q_data;
  logic                       q_empty;
  logic                       q_pop;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[arc_pkg::CFG_IDX_BIT];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (reg_idx == arc_pkg::REG_TGT_BASE) ?
                      arc_pkg::CFG_DW'(tgt_base_r) : arc_pkg::CFG_DW'(src_base_r);
  assign src_eff    = arc_pkg::eff_base(src_base_r);
  assign tgt_eff    = arc_pkg::eff_base(tgt_base_r);
  assign accept     = in_push && !in_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_base_r <= arc_pkg::BASE_W'(10);
      tgt_base_r <= arc_pkg::BASE_W'(10);
    end else if (cfg_wr) begin
      if (reg_idx == arc_pkg::REG_SRC_BASE) begin
        src_base_r <= cfg_pwdata[arc_pkg::BASE_W-1:0];
      end else begin
        tgt_base_r <= cfg_pwdata[arc_pkg::BASE_W-1:0];
      end
    end
  end

  arc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (in_data),
    .src_base (src_eff),
    .tgt_base (tgt_eff),
    .cmd      (front_cmd)
  );

  arc_cmd_fifo u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (front_cmd),
    .full  (in_full),
    .pop   (q_pop),
    .rdata (q_data),
    .empty (q_empty)
  );

  arc_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .src_base  (src_eff),
    .tgt_base  (tgt_eff),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

@@ design/arc_front.sv @@
module arc_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  arc_pkg::in_item_t              item,
  input  logic [arc_pkg::BASE_W-1:0]     src_base,
  input  logic [arc_pkg::BASE_W-1:0]     tgt_base,
  output arc_pkg::cmd_t                  cmd
);

  logic first_r;
  logic first_nxt;
  logic echo;
  logic is_sign;

  assign echo    = (src_base == tgt_base);
  assign is_sign = (item.char_in == arc_pkg::CH_PLUS) || (item.char_in == arc_pkg::CH_MINUS);

  always_comb begin
    cmd.chr   = item.char_in;
    cmd.last  = item.last_in;
    cmd.digit = arc_pkg::char_value(item.char_in);
    cmd.code  = arc_pkg::ST_OK;
    first_nxt = first_r;
    if (echo) begin
      cmd.kind = arc_pkg::CMD_ECHO;
      if (item.last_in) first_nxt = 1'b1;
    end else begin
      first_nxt = item.last_in;
      if (first_r && is_sign) begin
        cmd.kind = arc_pkg::CMD_SIGN;
      end else begin
        cmd.kind = arc_pkg::CMD_DIGIT;
        if (!arc_pkg::is_digit(item.char_in)) begin
          cmd.code = arc_pkg::ST_INVALID;
        end else if (cmd.digit >= src_base) begin
          cmd.code = arc_pkg::ST_RANGE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
    end else if (accept) begin
      first_r <= first_nxt;
    end
  end

endmodule

@@ design/arc_cmd_fifo.sv @@
module arc_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  arc_pkg::cmd_t wdata,
  output logic          full,
  input  logic          pop,
  output arc_pkg::cmd_t rdata,
  output logic          empty
);

  localparam int AW = $clog2(arc_pkg::CMDQ_DEPTH);

  arc_pkg::cmd_t  slots_r [arc_pkg::CMDQ_DEPTH];
  logic [AW-1:0]  wptr_r;
  logic [AW-1:0]  rptr_r;
  logic [AW:0]    cnt_r;
  logic           do_push;
  logic           do_pop;

  assign full    = (cnt_r == (AW+1)'(arc_pkg::CMDQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) slots_r[wptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) wptr_r <= wptr_r + 1'b1;
      if (do_pop)  rptr_r <= rptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

@@ design/arc_back.sv @@
module arc_back #(
  parameter int VALUE_BITS = 63
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  arc_pkg::cmd_t              q_data,
  output logic                       q_pop,
  input  logic [arc_pkg::BASE_W-1:0] src_base,
  input  logic [arc_pkg::BASE_W-1:0] tgt_base,
  output logic                       out_empty,
  input  logic                       out_pop,
  output arc_pkg::out_item_t         out_data
);

  localparam int BW = arc_pkg::BASE_W;
  localparam int PW = VALUE_BITS + BW;
  localparam int ND = (VALUE_BITS + 7) / 8;
  localparam int DW = ND * 8;
  localparam int SW = $clog2(ND + 1);

  arc_pkg::back_state_t state_r, state_nxt;
  arc_pkg::cmd_t        cur_r, cur_nxt;
  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic                  neg_r, neg_nxt;
  arc_pkg::status_t      err_r, err_nxt;
  logic [PW-1:0]         prod_r, prod_nxt;
  logic [DW-1:0]         dv_r, dv_nxt;
  logic [BW-1:0]         rem_r, rem_nxt;
  logic [SW-1:0]         step_r, step_nxt;
  logic [arc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [BW-1:0]         rd_r;
  logic                  out_vld_r, out_vld_nxt;
  arc_pkg::out_item_t    out_r, out_nxt;

  logic [BW-1:0]         dbuf [arc_pkg::BUF_DEPTH];
  logic                  mem_we;
  logic                  mem_re;
  logic [arc_pkg::CNT_W-1:0]  cnt_dec;
  logic [arc_pkg::BUF_AW-1:0] rd_addr;
  logic                  slot_free;
  logic                  out_load;
  logic [PW-1:0]         mac;
  logic [BW-1:0]         dv_rem;
  logic [7:0]            dv_q;

  assign slot_free = !out_vld_r || out_pop;
  assign out_empty = !out_vld_r;
  assign out_data  = out_r;
  assign cnt_dec   = cnt_r - arc_pkg::CNT_W'(1);
  assign rd_addr   = cnt_dec[arc_pkg::BUF_AW-1:0];
  assign mac       = PW'(mag_r) * PW'(src_base) + PW'(cur_r.digit);

  // one byte of restoring division by the target base
  always_comb begin : div_byte
    logic [BW:0]   t;
    logic [BW-1:0] r;
    r    = rem_r;
    dv_q = '0;
    for (int i = 0; i < 8; i++) begin
      t = {r, dv_r[DW-1-i]};
      if (t >= {1'b0, tgt_base}) begin
        t = t - {1'b0, tgt_base};
        dv_q[7-i] = 1'b1;
      end
      r = t[BW-1:0];
    end
    dv_rem = r;
  end

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    err_nxt   = err_r;
    prod_nxt  = prod_r;
    dv_nxt    = dv_r;
    rem_nxt   = rem_r;
    step_nxt  = step_r;
    cnt_nxt   = cnt_r;
    out_nxt   = out_r;
    out_load  = 1'b0;
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;

    case (state_r)
      arc_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cur_nxt   = q_data;
          state_nxt = arc_pkg::BK_EXEC;
        end
      end
      arc_pkg::BK_EXEC: begin
        case (cur_r.kind)
          arc_pkg::CMD_ECHO: begin
            if (slot_free) begin
              out_load  = 1'b1;
              out_nxt   = '{char_out: cur_r.chr, status: arc_pkg::ST_OK,
                            last_out: cur_r.last};
              state_nxt = arc_pkg::BK_IDLE;
              if (cur_r.last) begin
                mag_nxt = '0;
                neg_nxt = 1'b0;
                err_nxt = arc_pkg::ST_OK;
              end
            end
          end
          arc_pkg::CMD_SIGN: begin
            if (err_r == arc_pkg::ST_OK) neg_nxt = (cur_r.chr == arc_pkg::CH_MINUS);
            state_nxt = cur_r.last ? arc_pkg::BK_END : arc_pkg::BK_IDLE;
          end
          arc_pkg::CMD_DIGIT: begin
            if (err_r != arc_pkg::ST_OK) begin
              state_nxt = cur_r.last ? arc_pkg::BK_END : arc_pkg::BK_IDLE;
            end else if (cur_r.code != arc_pkg::ST_OK) begin
              err_nxt   = cur_r.code;
              state_nxt = cur_r.last ? arc_pkg::BK_END : arc_pkg::BK_IDLE;
            end else begin
              prod_nxt  = mac;
              state_nxt = arc_pkg::BK_ACC;
            end
          end
          default: state_nxt = arc_pkg::BK_IDLE;
        endcase
      end
      arc_pkg::BK_ACC: begin
        if (|prod_r[PW-1:VALUE_BITS]) begin
          err_nxt = arc_pkg::ST_OVERFLOW;
        end else begin
          mag_nxt = prod_r[VALUE_BITS-1:0];
        end
        state_nxt = cur_r.last ? arc_pkg::BK_END : arc_pkg::BK_IDLE;
      end
      arc_pkg::BK_END: begin
        if (err_r != arc_pkg::ST_OK) begin
          if (slot_free) begin
            out_load  = 1'b1;
            out_nxt   = '{char_out: arc_pkg::CH_NUL, status: err_r, last_out: 1'b1};
            mag_nxt   = '0;
            neg_nxt   = 1'b0;
            err_nxt   = arc_pkg::ST_OK;
            state_nxt = arc_pkg::BK_IDLE;
          end
        end else begin
          dv_nxt    = DW'(mag_r);
          cnt_nxt   = '0;
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = arc_pkg::BK_DIV;
        end
      end
      arc_pkg::BK_DIV: begin
        dv_nxt   = (dv_r << 8) | DW'(dv_q);
        rem_nxt  = dv_rem;
        step_nxt = step_r + 1'b1;
        if (step_r == SW'(ND - 1)) begin
          mem_we    = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = arc_pkg::BK_NEXT;
        end
      end
      arc_pkg::BK_NEXT: begin
        if (dv_r != '0 && cnt_r < arc_pkg::CNT_W'(arc_pkg::MAX_DIGITS)) begin
          state_nxt = arc_pkg::BK_DIV;
        end else begin
          state_nxt = arc_pkg::BK_SIGN;
        end
      end
      arc_pkg::BK_SIGN: begin
        if (neg_r && mag_r != '0) begin
          if (slot_free) begin
            out_load  = 1'b1;
            out_nxt   = '{char_out: arc_pkg::CH_MINUS, status: arc_pkg::ST_OK,
                          last_out: 1'b0};
            state_nxt = arc_pkg::BK_RD;
          end
        end else begin
          state_nxt = arc_pkg::BK_RD;
        end
      end
      arc_pkg::BK_RD: begin
        mem_re    = 1'b1;
        cnt_nxt   = cnt_dec;
        state_nxt = arc_pkg::BK_EMIT;
      end
      arc_pkg::BK_EMIT: begin
        if (slot_free) begin
          out_load = 1'b1;
          out_nxt  = '{char_out: arc_pkg::digit_char(rd_r), status: arc_pkg::ST_OK,
                       last_out: (cnt_r == '0)};
          if (cnt_r == '0) begin
            mag_nxt   = '0;
            neg_nxt   = 1'b0;
            err_nxt   = arc_pkg::ST_OK;
            state_nxt = arc_pkg::BK_IDLE;
          end else begin
            state_nxt = arc_pkg::BK_RD;
          end
        end
      end
      default: state_nxt = arc_pkg::BK_IDLE;
    endcase

    if (out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_pop) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  // digits land least significant first; read back from the top down
  always_ff @(posedge clk) begin
    if (mem_we) dbuf[cnt_r[arc_pkg::BUF_AW-1:0]] <= dv_rem;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rd_r <= dbuf[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= arc_pkg::BK_IDLE;
      mag_r     <= '0;
      neg_r     <= 1'b0;
      err_r     <= arc_pkg::ST_OK;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      mag_r     <= mag_nxt;
      neg_r     <= neg_nxt;
      err_r     <= err_nxt;
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    prod_r <= prod_nxt;
    dv_r   <= dv_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    out_r  <= out_nxt;
  end

endmodule

@@ design/arc_checker.sv @@
module arc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_full,
  input logic                        out_empty,
  input logic                        out_pop,
  input arc_pkg::out_item_t          out_data,
  input logic                        cfg_psel,
  input logic                        cfg_penable,
  input logic                        cfg_pready
);

  // reset drains both queues
  a_reset_drain: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // an error result carries no character and closes the numeral
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.status != arc_pkg::ST_OK |->
      out_data.char_out == arc_pkg::CH_NUL && out_data.last_out)
    else $error("malformed error result");

  // a waiting result holds until popped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_data))
    else $error("result changed while waiting");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable |-> cfg_pready)
    else $error("config access stalled");

endmodule

bind ascii_radix_converter arc_checker u_arc_checker (.*);

@@ sim/tb_ascii_radix_converter.sv @@
`timescale 1ns / 100ps

module tb_ascii_radix_converter;
  import arc_pkg::*;

  localparam bit [63:0] MAX_MAG = 64'h7FFF_FFFF_FFFF_FFFF;

  logic                clk;
  logic                rst_n;
  logic                in_push;
  logic                in_full;
  in_item_t            in_data;
  logic                out_empty;
  logic                out_pop;
  out_item_t           out_data;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CFG_AW-1:0]   cfg_paddr;
  logic [CFG_DW-1:0]   cfg_pwdata;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  int unsigned chars_sent;
  bit          in_calm;
  bit          out_calm;

  ascii_radix_converter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_data    (in_data),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  function automatic logic [CHAR_W-1:0] digit_text(int unsigned d, bit lower);
    if (d < DEC_DIGITS) return CH_0 + CHAR_W'(d);
    return (lower ? CH_LA : CH_UA) + CHAR_W'(d - DEC_DIGITS);
  endfunction

  function automatic int unsigned radix_of(logic [BASE_W-1:0] v);
    if (v < BASE_MIN) return BASE_MIN;
    if (v > BASE_MAX) return BASE_MAX;
    return v;
  endfunction

  // number of digits that the largest magnitude takes in this radix
  function automatic int unsigned max_digits(int unsigned radix);
    bit [63:0]   n;
    int unsigned cnt;
    n = MAX_MAG;
    cnt = 0;
    while (n != 0) begin
      n = n / radix;
      cnt++;
    end
    return cnt;
  endfunction

  class numeral_checker;
    logic [BASE_W-1:0] src_reg;
    logic [BASE_W-1:0] tgt_reg;
    bit [63:0]         magnitude;
    bit                negative;
    bit                first;
    status_t           err;
    out_item_t         expected_chars[$];
    int                mismatch_count;

    function new();
      src_reg = BASE_W'(DEC_DIGITS);
      tgt_reg = BASE_W'(DEC_DIGITS);
      mismatch_count = 0;
      clear_numeral();
    endfunction

    function void clear_numeral();
      magnitude = '0;
      negative = 1'b0;
      first = 1'b1;
      err = ST_OK;
    endfunction

    function void set_reg(logic idx, logic [BASE_W-1:0] v);
      if (idx == REG_SRC_BASE) src_reg = v;
      else tgt_reg = v;
    endfunction

    function int unsigned source_radix();
      return radix_of(src_reg);
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    function void add(logic [CHAR_W-1:0] c, status_t st, logic last);
      out_item_t r;
      r.char_out = c;
      r.status = st;
      r.last_out = last;
      expected_chars.push_back(r);
    endfunction

    function void take_char(in_item_t item);
      bit [63:0]   sb;
      bit [63:0]   tb;
      bit [63:0]   d;
      bit [63:0]   n;
      int          v;
      int unsigned digits[$];
      logic [CHAR_W-1:0] c;
      c = item.char_in;
      sb = radix_of(src_reg);
      tb = radix_of(tgt_reg);
      if (sb == tb) begin
        add(c, ST_OK, item.last_in);
        if (item.last_in) clear_numeral();
        return;
      end
      if (err == ST_OK) begin
        if (first && (c == CH_PLUS || c == CH_MINUS)) begin
          negative = (c == CH_MINUS);
        end else begin
          if (c >= CH_0 && c <= CH_9) v = c - CH_0;
          else if (c >= CH_UA && c <= CH_UZ) v = c - CH_UA + DEC_DIGITS;
          else if (c >= CH_LA && c <= CH_LZ) v = c - CH_LA + DEC_DIGITS;
          else v = -1;
          d = v;
          if (v < 0) err = ST_INVALID;
          else if (d >= sb) err = ST_RANGE;
          else if (magnitude > (MAX_MAG - d) / sb) err = ST_OVERFLOW;
          else magnitude = magnitude * sb + d;
        end
      end
      first = 1'b0;
      if (!item.last_in) return;
      if (err != ST_OK) begin
        add(CH_NUL, err, 1'b1);
        clear_numeral();
        return;
      end
      n = magnitude;
      do begin
        digits.push_front(int'(n % tb));
        n = n / tb;
      end while (n != 0 && digits.size() < MAX_DIGITS);
      if (negative && magnitude != 0) add(CH_MINUS, ST_OK, 1'b0);
      foreach (digits[i]) add(digit_text(digits[i], 1'b0), ST_OK, i == digits.size() - 1);
      clear_numeral();
    endfunction

    function void match_char(out_item_t got);
      out_item_t want;
      if (expected_chars.size() == 0) begin
        $error("unexpected result: char_out %h status %0d last_out %0b",
               got.char_out, got.status, got.last_out);
        mismatch_count++;
        return;
      end
      want = expected_chars.pop_front();
      if (got.char_out !== want.char_out) begin
        $error("char_out: expected %h, actual %h", want.char_out, got.char_out);
        mismatch_count++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        mismatch_count++;
      end
      if (got.last_out !== want.last_out) begin
        $error("last_out: expected %0b, actual %0b", want.last_out, got.last_out);
        mismatch_count++;
      end
    endfunction
  endclass

  numeral_checker book = new();

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic send_char(in_item_t item);
    int unsigned gap;
    gap = in_calm ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      in_push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push = 1'b1;
    in_data = item;
    do @(posedge clk); while (in_full);
    book.take_char(item);
    chars_sent++;
  endtask

  task automatic send_text(string s);
    in_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.char_in = s[i];
      it.last_in = (i == s.len() - 1);
      send_char(it);
    end
  endtask

  task automatic write_reg(logic idx, logic [BASE_W-1:0] v);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = '0;
    cfg_paddr[CFG_IDX_BIT] = idx;
    // junk in the upper bits must be dropped
    cfg_pwdata = {(CFG_DW - BASE_W)'($urandom()), v};
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    book.set_reg(idx, v);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  task automatic set_bases(logic [BASE_W-1:0] src, logic [BASE_W-1:0] tgt);
    @(negedge clk);
    in_push = 1'b0;
    while (book.pending() != 0) @(negedge clk);
    // let the engine drain characters that produce no result
    repeat (40) @(negedge clk);
    write_reg(REG_SRC_BASE, src);
    write_reg(REG_TGT_BASE, tgt);
  endtask

  function automatic logic [BASE_W-1:0] pick_base();
    logic [BASE_W-1:0] edges[6] = '{0, 1, 2, 36, 37, 63};
    case ($urandom_range(0, 3))
      0: return edges[$urandom_range(0, 5)];
      1: return BASE_W'($urandom_range(0, 63));
      default: return BASE_W'($urandom_range(BASE_MIN, BASE_MAX));
    endcase
  endfunction

  task automatic send_random_numeral();
    in_item_t    seq[$];
    in_item_t    it;
    int unsigned sb;
    int unsigned len;
    int unsigned kind;
    int unsigned pos;
    sb = book.source_radix();
    kind = $urandom_range(0, 9);
    it.last_in = 1'b0;
    if (kind == 9) begin
      len = $urandom_range(1, 4);
      repeat (len) begin
        it.char_in = CHAR_W'($urandom());
        seq.push_back(it);
      end
    end else if (kind == 8) begin
      it.char_in = $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
      seq.push_back(it);
    end else begin
      case ($urandom_range(0, 3))
        1: begin it.char_in = CH_PLUS; seq.push_back(it); end
        2: begin it.char_in = CH_MINUS; seq.push_back(it); end
        default: ;
      endcase
      // mostly short numerals; some long enough to reach overflow
      if ($urandom_range(0, 4) == 0)
        len = $urandom_range(max_digits(sb) - 1, max_digits(sb) + 1);
      else
        len = $urandom_range(1, 6);
      repeat (len) begin
        it.char_in = digit_text($urandom_range(0, sb - 1), $urandom_range(0, 1));
        seq.push_back(it);
      end
      if (kind == 7) begin
        pos = $urandom_range(0, seq.size() - 1);
        case ($urandom_range(0, 2))
          0: seq[pos].char_in = CHAR_W'($urandom());
          1: seq[pos].char_in = (sb < BASE_MAX) ?
               digit_text($urandom_range(sb, BASE_MAX - 1), $urandom_range(0, 1)) :
               CHAR_W'($urandom());
          default: seq[pos].char_in = $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
        endcase
      end
    end
    seq[seq.size() - 1].last_in = 1'b1;
    foreach (seq[i]) send_char(seq[i]);
  endtask

  initial begin
    int unsigned gap;
    out_pop = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = out_calm ? 0 : $urandom_range(0, 6);
      @(negedge clk);
      if (gap > 0) begin
        out_pop = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_pop = 1'b1;
      do @(posedge clk); while (out_empty);
      book.match_char(out_data);
    end
  end

  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [BASE_W-1:0] src;
    logic [BASE_W-1:0] tgt;
    int unsigned       stop_at;
    in_item_t          it;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    chars_sent = 0;
    in_calm = 1'b0;
    out_calm = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset bases are equal: echo
    send_text("7");

    set_bases(36, 2);
    send_text("-1y2p0ij32e8e7");  // largest magnitude, 63 binary digits
    send_text("+");
    send_text("-0");
    send_text("a+");              // sign after the first character
    send_text("{");

    set_bases(2, 36);
    send_text("2");               // digit beyond the base

    set_bases(1, 0);              // both clamp to 2: echo
    it.char_in = 8'hFF;
    it.last_in = 1'b0;
    send_char(it);
    it.char_in = CH_NUL;
    it.last_in = 1'b1;
    send_char(it);

    while (chars_sent < 450) begin
      src = pick_base();
      tgt = ($urandom_range(0, 5) == 0) ? src : pick_base();
      set_bases(src, tgt);
      in_calm = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      stop_at = chars_sent + $urandom_range(20, 60);
      while (chars_sent < stop_at) send_random_numeral();
    end

    @(negedge clk);
    in_push = 1'b0;
    while (book.pending() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (book.mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
